// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CHK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ogc_pkg.sv -----
// shared types, constants and helper functions of the occupancy grid unit
package ogc_pkg;

	// default grid geometry
	localparam int GRID_FWD_DEF    = 128;
	localparam int GRID_SIDE_DEF   = 64;
	localparam int SIDE_OFFSET_DEF = 32;

	// coordinate width (q16 cells) and quotient width of the walk
	localparam int CW = 36;
	localparam int QW = 40;

	// cordic
	localparam int CORDIC_STEPS = 14;
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

	// request codes
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_MARK  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// register indexes
	localparam logic [2:0] CFG_ANGLE_START = 3'd0;
	localparam logic [2:0] CFG_ANGLE_STEP  = 3'd1;
	localparam logic [2:0] CFG_CPM         = 3'd2;
	localparam logic [2:0] CFG_DILATION    = 3'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [10:0]        beam_index;
		logic [15:0]        range_mm;
		logic signed [15:0] start_fwd_mm;
		logic signed [15:0] start_side_mm;
		logic signed [15:0] end_fwd_mm;
		logic signed [15:0] end_side_mm;
	} req_t;

	typedef struct packed {
		logic [1:0] kind_done;
		logic       collision;
		logic       hit_in_grid;
	} res_t;

	// operands of the serial multiply-divide unit
	typedef struct packed {
		logic [CW-1:0] mcand;
		logic [CW-1:0] mplier;
		logic [CW-1:0] divisor;
	} md_op_t;

	// arctangent table in binary angle units
	function automatic logic signed [17:0] atan_lut(input logic [3:0] i);
		logic signed [17:0] v;
		case (i)
			4'd0:  v = 18'sd8192;
			4'd1:  v = 18'sd4836;
			4'd2:  v = 18'sd2555;
			4'd3:  v = 18'sd1297;
			4'd4:  v = 18'sd651;
			4'd5:  v = 18'sd326;
			4'd6:  v = 18'sd163;
			4'd7:  v = 18'sd81;
			4'd8:  v = 18'sd41;
			4'd9:  v = 18'sd20;
			4'd10: v = 18'sd10;
			4'd11: v = 18'sd5;
			4'd12: v = 18'sd3;
			4'd13: v = 18'sd1;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction

	// round q4.30 to q1.15 to nearest (half up) and saturate
	function automatic logic signed [15:0] sat_q15(input logic signed [33:0] v);
		logic signed [34:0] t;
		logic signed [19:0] r;
		logic signed [15:0] o;
		t = {v[33], v} + 35'sd16384;
		r = t[34:15];
		if (r > 20'sd32767) begin
			o = 16'sh7fff;
		end else if (r < -20'sd32768) begin
			o = 16'sh8000;
		end else begin
			o = r[15:0];
		end
		return o;
	endfunction

endpackage

// ----- rtl/ogc_ram.sv -----
// generic single write port ram with registered read
module ogc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/ogc_muldiv.sv -----
// bit-serial floor(mcand * mplier / divisor) for mplier not above divisor
`include "assert_macros.svh"
module ogc_muldiv
	import ogc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  md_op_t        op,
	output logic          done,
	output logic [QW-1:0] quot,
	output logic [CW-1:0] rem
);

	localparam int CNT_W = $clog2(CW);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    mc_q;
	logic [CW-1:0]    mp_q;
	logic [CW-1:0]    d_q;
	logic [CW-1:0]    rem_q;
	logic [QW-1:0]    quo_q;
	logic             done_q;

	logic [CW+1:0] t_c;
	logic [CW+1:0] d1_c;
	logic [CW+1:0] d2_c;
	logic [CW+1:0] tr_c;
	logic [1:0]    dig_c;

	// one multiplicand bit per cycle: shift-add, then take out up to two divisors
	always_comb begin
		d1_c = {2'b00, d_q};
		d2_c = {1'b0, d_q, 1'b0};
		t_c  = {1'b0, rem_q, 1'b0} + (mc_q[CW-1] ? {2'b00, mp_q} : '0);
		if (t_c >= d2_c) begin
			tr_c  = t_c - d2_c;
			dig_c = 2'd2;
		end else if (t_c >= d1_c) begin
			tr_c  = t_c - d1_c;
			dig_c = 2'd1;
		end else begin
			tr_c  = t_c;
			dig_c = 2'd0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= op.mcand;
			mp_q  <= op.mplier;
			d_q   <= op.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			mc_q  <= {mc_q[CW-2:0], 1'b0};
			rem_q <= tr_c[CW-1:0];
			quo_q <= {quo_q[QW-2:0], 1'b0} + {{(QW-2){1'b0}}, dig_c};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

	`CHK_NOW(a_rem_below_div, done, rem_q < d_q, "remainder not below divisor")
	`CHK_NOW(a_no_restart, start, !run_q, "division started while running")
	`CHK_NEXT(a_run_after_start, start, run_q && cnt_q == '0, "division did not begin")

endmodule

// ----- rtl/occupancy_grid_mark_and_line_check_unit.sv -----
// occupancy grid: clear, beam marking with dilation and segment collision query
// Usage: a request (req) is taken at a rising edge with start high and busy
// low; busy falls in the cycle in which its result is issued, so the next
// request can be taken then. Each request gives one result on res, valid for
// the single cycle in which done is high; the receiver cannot stall and must
// take it then. Request type 3 is taken and dropped without a result.
// Configuration is written over cfg_valid / cfg_ready (always ready) with
// cfg_index and cfg_data; the user must write it only while idle, and the
// block itself does not enforce this.
// Steps from the accepting edge to the cycle with done high:
//   clear: every grid cell is written free, one grid memory word per cycle
//   mark:  the angle check ends a beam outside the half circle; else the
//          14-step cordic and two multiplies (an off-grid hit ends there),
//          then (2*dilation_radius+1)^2 cells, each written if on the grid
//   query: set-up ends it if the walk covers no column; else set-up and two
//          serial divisions, then a read and a check per column crossed,
//          ending early on the first occupied cell
// Reset: registers take their reset values and the grid is swept free with
// busy high; configuration is taken meanwhile.
`include "assert_macros.svh"
module occupancy_grid_mark_and_line_check_unit
	import ogc_pkg::*;
#(
	parameter int GRID_FWD    = GRID_FWD_DEF,
	parameter int GRID_SIDE   = GRID_SIDE_DEF,
	parameter int SIDE_OFFSET = SIDE_OFFSET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH = GRID_FWD * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int GMAX  = (GRID_FWD > GRID_SIDE) ? GRID_FWD : GRID_SIDE;
	localparam int UW    = $clog2(GMAX) + 1;
	localparam logic signed [CW-1:0] OFF_Q16 = CW'(SIDE_OFFSET * 65536);

	// sequencer codes
	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_ANG    = 5'd2;
	localparam logic [4:0] S_CORD   = 5'd3;
	localparam logic [4:0] S_SAT    = 5'd4;
	localparam logic [4:0] S_MUL1   = 5'd5;
	localparam logic [4:0] S_MUL2   = 5'd6;
	localparam logic [4:0] S_MCHK   = 5'd7;
	localparam logic [4:0] S_DIL    = 5'd8;
	localparam logic [4:0] S_QA     = 5'd9;
	localparam logic [4:0] S_QB     = 5'd10;
	localparam logic [4:0] S_QD     = 5'd11;
	localparam logic [4:0] S_QSW    = 5'd12;
	localparam logic [4:0] S_QLIM   = 5'd13;
	localparam logic [4:0] S_QSTART = 5'd14;
	localparam logic [4:0] S_QDS    = 5'd15;
	localparam logic [4:0] S_QD0    = 5'd16;
	localparam logic [4:0] S_WALK   = 5'd17;
	localparam logic [4:0] S_CHK    = 5'd18;

	// configuration registers
	logic signed [15:0] angle_start_q;
	logic [9:0]         angle_step_q;
	logic [15:0]        cpm_q;
	logic [2:0]         dil_q;

	// control
	logic [4:0]    state_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_res_q;
	logic          done_q;
	res_t          res_q;
	logic [1:0]    kind_q;

	// request payload
	logic [10:0]        beam_q;
	logic [15:0]        range_q;
	logic signed [15:0] sf_q, ss_q, ef_q, es_q;

	// mark path
	logic signed [22:0] theta_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [17:0] cz_q;
	logic [3:0]         it_q;
	logic signed [15:0] cos_q, sin_q;
	logic signed [32:0] pc_q, ps_q;
	logic signed [19:0] cf_q, cs_q;
	logic signed [3:0]  dj_q, dk_q;

	// query path
	logic signed [CW-1:0] pa0_q, pa1_q, pb0_q, pb1_q;
	logic [CW-1:0]        dx_q, dy_q;
	logic                 mi_q;
	logic signed [CW-1:0] ai_q, aj_q, bi_q, bj_q;
	logic signed [CW-1:0] di_q, dlt_q, du0_q;
	logic [UW-1:0]        u_q, hi_q;
	logic signed [QW-1:0] qs_q, qc_q;
	logic [CW-1:0]        rs_q, rc_q;
	logic                 chk_q;

	// memory
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic          mem_rdata;

	// divider
	logic          md_start;
	md_op_t        md_op;
	logic          md_done;
	logic [QW-1:0] md_quot;
	logic [CW-1:0] md_rem;

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	// beam angle
	logic [20:0]        bprod_c;
	logic signed [22:0] theta_c;
	assign bprod_c = 21'(beam_q) * 21'(angle_step_q);
	assign theta_c = {{7{angle_start_q[15]}}, angle_start_q} + $signed({2'b00, bprod_c});

	// one cordic rotation
	logic signed [33:0] xs_c, ys_c;
	logic signed [17:0] at_c;
	assign xs_c = cx_q >>> it_q;
	assign ys_c = cy_q >>> it_q;
	assign at_c = atan_lut(it_q);

	// mark multiplies
	logic signed [32:0] pc_c, ps_c;
	logic signed [49:0] fp_c, sp_c;
	logic signed [16:0] cpm_s;
	assign cpm_s = $signed({1'b0, cpm_q});
	assign pc_c  = $signed({1'b0, range_q}) * cos_q;
	assign ps_c  = $signed({1'b0, range_q}) * sin_q;
	assign fp_c  = pc_q * cpm_s;
	assign sp_c  = ps_q * cpm_s;

	// dilation cell
	logic signed [3:0]  rad_c;
	logic signed [19:0] dcf_c, dcs_c;
	logic               din_c;
	assign rad_c = $signed({1'b0, dil_q});
	assign dcf_c = cf_q + 20'(dj_q);
	assign dcs_c = cs_q + 20'(dk_q);
	assign din_c = (dcf_c >= 0) && (dcf_c < 20'(GRID_FWD))
		&& (dcs_c >= 0) && (dcs_c < 20'(GRID_SIDE));

	// query point multiplies
	logic signed [32:0] qm0_c, qm1_c;
	assign qm0_c = (state_q == S_QA ? sf_q : ef_q) * cpm_s;
	assign qm1_c = (state_q == S_QA ? ss_q : es_q) * cpm_s;

	// major axis choice and ordering
	logic                 msel_c, swap_c;
	logic signed [CW-1:0] ai_c, bi_c;
	assign msel_c = !(dx_q > dy_q);
	assign ai_c   = msel_c ? pa1_q : pa0_q;
	assign bi_c   = msel_c ? pb1_q : pb0_q;
	assign swap_c = ai_c > bi_c;

	// walk limits
	logic signed [CW-17:0] t1_c, t2_c, lo_c, hi_c, limi_c;
	logic                  walk_c;
	assign t1_c   = ai_q[CW-1:16];
	assign t2_c   = bi_q[CW-1:16];
	assign limi_c = mi_q ? (CW-16)'(GRID_SIDE) : (CW-16)'(GRID_FWD);
	assign lo_c   = (t1_c < 0) ? '0 : t1_c;
	assign hi_c   = (t2_c > limi_c) ? limi_c : t2_c;
	assign walk_c = lo_c < hi_c;

	// divider operands and signed floor of its result
	logic [CW-1:0]        adj_c, adu_c;
	logic                 neg_c;
	logic signed [QW-1:0] cq_c;
	logic [CW-1:0]        cr_c;
	assign adj_c = dlt_q[CW-1] ? CW'(-dlt_q) : CW'(dlt_q);
	assign adu_c = du0_q[CW-1] ? CW'(-du0_q) : CW'(du0_q);
	assign md_start = (state_q == S_QSTART) || (state_q == S_QDS && md_done);
	assign md_op.mcand   = (state_q == S_QSTART) ? CW'(65536) : adu_c;
	assign md_op.mplier  = adj_c;
	assign md_op.divisor = di_q;
	assign neg_c = (state_q == S_QDS) ? dlt_q[CW-1] : (du0_q[CW-1] != dlt_q[CW-1]);
	always_comb begin
		if (neg_c && md_rem != '0) begin
			cq_c = -$signed(md_quot) - QW'(1);
			cr_c = di_q - md_rem;
		end else if (neg_c) begin
			cq_c = -$signed(md_quot);
			cr_c = '0;
		end else begin
			cq_c = $signed(md_quot);
			cr_c = md_rem;
		end
	end

	// cell of the current column
	logic signed [QW:0]    vs_c;
	logic signed [QW-16:0] cj_c, limj_c;
	logic                  cin_c;
	assign vs_c   = {{(QW+1-CW){aj_q[CW-1]}}, aj_q} + {qc_q[QW-1], qc_q};
	assign cj_c   = vs_c[QW:16];
	assign limj_c = mi_q ? (QW-15)'(GRID_FWD) : (QW-15)'(GRID_SIDE);
	assign cin_c  = (cj_c >= 0) && (cj_c < limj_c);

	// step to the next column
	logic [CW:0]          rsum_c;
	logic                 cy_c;
	logic [CW-1:0]        rn_c;
	logic signed [QW-1:0] qn_c;
	assign rsum_c = {1'b0, rc_q} + {1'b0, rs_q};
	assign cy_c   = rsum_c >= {1'b0, di_q};
	assign rn_c   = cy_c ? CW'(rsum_c - {1'b0, di_q}) : CW'(rsum_c);
	assign qn_c   = qc_q + qs_q + QW'(cy_c);

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = 1'b0;
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
		end else if (state_q == S_DIL) begin
			mem_we    = din_c;
			mem_waddr = AW'(dcf_c) + AW'(dcs_c) * AW'(GRID_FWD);
			mem_wdata = 1'b1;
		end
		if (mi_q) begin
			mem_raddr = AW'(cj_c) + AW'(u_q) * AW'(GRID_FWD);
		end else begin
			mem_raddr = AW'(u_q) + AW'(cj_c) * AW'(GRID_FWD);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= -16'sd24576;
			angle_step_q  <= 10'd46;
			cpm_q         <= 16'd1311;
			dil_q         <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ANGLE_START: angle_start_q <= $signed(cfg_data);
				CFG_ANGLE_STEP:  angle_step_q  <= cfg_data[9:0];
				CFG_CPM:         cpm_q         <= cfg_data;
				CFG_DILATION:    dil_q         <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			clr_res_q  <= 1'b0;
			done_q     <= 1'b0;
			res_q      <= '0;
			kind_q     <= REQ_CLEAR;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						clr_addr_q <= '0;
						state_q    <= S_IDLE;
						if (clr_res_q) begin
							done_q    <= 1'b1;
							res_q     <= '{kind_done: REQ_CLEAR, collision: 1'b0,
								hit_in_grid: 1'b0};
							clr_res_q <= 1'b0;
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						kind_q <= req.req_type;
						unique case (req.req_type)
							REQ_CLEAR: begin
								clr_res_q <= 1'b1;
								state_q   <= S_CLR;
							end
							REQ_MARK:  state_q <= S_ANG;
							REQ_QUERY: state_q <= S_QA;
							default: ;
						endcase
					end
				end
				S_ANG: begin
					if (theta_c < -23'sd16384 || theta_c > 23'sd16384) begin
						done_q  <= 1'b1;
						res_q   <= '{kind_done: kind_q, collision: 1'b0, hit_in_grid: 1'b0};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (it_q == 4'(CORDIC_STEPS - 1)) begin
						state_q <= S_SAT;
					end
				end
				S_SAT:  state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MCHK;
				S_MCHK: begin
					if (cf_q >= 0 && cf_q < 20'(GRID_FWD) && cs_q >= 0
						&& cs_q < 20'(GRID_SIDE)) begin
						state_q <= S_DIL;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{kind_done: kind_q, collision: 1'b0, hit_in_grid: 1'b0};
						state_q <= S_IDLE;
					end
				end
				S_DIL: begin
					if (dk_q == rad_c && dj_q == rad_c) begin
						done_q  <= 1'b1;
						res_q   <= '{kind_done: kind_q, collision: 1'b0, hit_in_grid: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_QA:  state_q <= S_QB;
				S_QB:  state_q <= S_QD;
				S_QD:  state_q <= S_QSW;
				S_QSW: state_q <= S_QLIM;
				S_QLIM: begin
					if (walk_c) begin
						state_q <= S_QSTART;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{kind_done: kind_q, collision: 1'b0, hit_in_grid: 1'b0};
						state_q <= S_IDLE;
					end
				end
				S_QSTART: state_q <= S_QDS;
				S_QDS: begin
					if (md_done) begin
						state_q <= S_QD0;
					end
				end
				S_QD0: begin
					if (md_done) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: state_q <= S_CHK;
				S_CHK: begin
					if (chk_q && mem_rdata) begin
						done_q  <= 1'b1;
						res_q   <= '{kind_done: kind_q, collision: 1'b1, hit_in_grid: 1'b0};
						state_q <= S_IDLE;
					end else if (u_q + 1'b1 == hi_q) begin
						done_q  <= 1'b1;
						res_q   <= '{kind_done: kind_q, collision: 1'b0, hit_in_grid: 1'b0};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WALK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				beam_q  <= req.beam_index;
				range_q <= req.range_mm;
				sf_q    <= req.start_fwd_mm;
				ss_q    <= req.start_side_mm;
				ef_q    <= req.end_fwd_mm;
				es_q    <= req.end_side_mm;
			end
			S_ANG: begin
				theta_q <= theta_c;
				cx_q    <= CORDIC_K;
				cy_q    <= '0;
				cz_q    <= theta_c[17:0];
				it_q    <= '0;
			end
			S_CORD: begin
				it_q <= it_q + 1'b1;
				if (cz_q >= 0) begin
					cx_q <= cx_q - ys_c;
					cy_q <= cy_q + xs_c;
					cz_q <= cz_q - at_c;
				end else begin
					cx_q <= cx_q + ys_c;
					cy_q <= cy_q - xs_c;
					cz_q <= cz_q + at_c;
				end
			end
			S_SAT: begin
				cos_q <= sat_q15(cx_q);
				sin_q <= sat_q15(cy_q);
			end
			S_MUL1: begin
				pc_q <= pc_c;
				ps_q <= ps_c;
			end
			S_MUL2: begin
				cf_q <= {fp_c[49], fp_c[49:31]};
				cs_q <= {sp_c[49], sp_c[49:31]} + 20'(SIDE_OFFSET);
			end
			S_MCHK: begin
				dj_q <= -rad_c;
				dk_q <= -rad_c;
			end
			S_DIL: begin
				if (dk_q == rad_c) begin
					dk_q <= -rad_c;
					dj_q <= dj_q + 4'sd1;
				end else begin
					dk_q <= dk_q + 4'sd1;
				end
			end
			S_QA: begin
				pa0_q <= {{(CW-33){qm0_c[32]}}, qm0_c};
				pa1_q <= {{(CW-33){qm1_c[32]}}, qm1_c} + OFF_Q16;
			end
			S_QB: begin
				pb0_q <= {{(CW-33){qm0_c[32]}}, qm0_c};
				pb1_q <= {{(CW-33){qm1_c[32]}}, qm1_c} + OFF_Q16;
			end
			S_QD: begin
				dx_q <= (pa0_q > pb0_q) ? CW'(pa0_q - pb0_q) : CW'(pb0_q - pa0_q);
				dy_q <= (pa1_q > pb1_q) ? CW'(pa1_q - pb1_q) : CW'(pb1_q - pa1_q);
			end
			S_QSW: begin
				mi_q <= msel_c;
				ai_q <= swap_c ? bi_c : ai_c;
				bi_q <= swap_c ? ai_c : bi_c;
				if (msel_c) begin
					aj_q <= swap_c ? pb0_q : pa0_q;
					bj_q <= swap_c ? pa0_q : pb0_q;
				end else begin
					aj_q <= swap_c ? pb1_q : pa1_q;
					bj_q <= swap_c ? pa1_q : pb1_q;
				end
			end
			S_QLIM: begin
				di_q  <= bi_q - ai_q;
				dlt_q <= bj_q - aj_q;
				du0_q <= $signed({lo_c, 16'h0000}) - ai_q;
				u_q   <= UW'(lo_c);
				hi_q  <= UW'(hi_c);
			end
			S_QDS: begin
				if (md_done) begin
					qs_q <= cq_c;
					rs_q <= cr_c;
				end
			end
			S_QD0: begin
				if (md_done) begin
					qc_q <= cq_c;
					rc_q <= cr_c;
				end
			end
			S_WALK: chk_q <= cin_c;
			S_CHK: begin
				u_q  <= u_q + 1'b1;
				qc_q <= qn_c;
				rc_q <= rn_c;
			end
			default: ;
		endcase
	end

	ogc_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ogc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.op     (md_op),
		.done   (md_done),
		.quot   (md_quot),
		.rem    (md_rem)
	);

	`CHK_NOW(a_done_ends_busy, done, !busy && $past(busy), "result without a busy period")
	`CHK_NEXT(a_accept_busy, start && !busy && req.req_type != REQ_NONE, busy,
		"request taken but not busy")
	`CHK_NOW(a_write_states, mem_we, state_q == S_CLR || state_q == S_DIL,
		"grid written outside clear or mark")
	`CHK_NOW(a_theta_in_span, state_q == S_CORD,
		theta_q >= -23'sd16384 && theta_q <= 23'sd16384, "rotation of a skipped beam")

endmodule
